// ===== rtl/core/lps_pkg.sv =====
// lps_pkg: shared types and constants for the LED pattern sequencer.
// Used by lps_tick_unit and led_pattern_sequencer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

	// fixed field widths
	localparam int TICK_BITS   = 10;
	localparam int DUR_IN_BITS = 16;
	localparam int ACT_BITS    = 3;
	localparam int FUNC_BITS   = 2;
	localparam int IDX_BITS    = 3;
	localparam int OUT_BITS    = 8;

	// parameter defaults
	localparam int CHANNELS_DEF      = 8;
	localparam int PATTERNS_DEF      = 8;
	localparam int STEPS_DEF         = 8;
	localparam int DURATION_BITS_DEF = 16;

	localparam logic [TICK_BITS-1:0] TICK_MS_RESET = TICK_BITS'(10);

	// command codes
	localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_WRITE   = 2'd2;

	// step action codes
	localparam logic [ACT_BITS-1:0] ACT_START    = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_ON       = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_OFF      = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_TOGGLE   = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_CONTINUE = 3'd4;
	localparam logic [ACT_BITS-1:0] ACT_STOP     = 3'd5;

	// one pattern table entry
	typedef struct packed {
		logic [ACT_BITS-1:0]    action;
		logic [DUR_IN_BITS-1:0] duration;
	} tbl_entry_t;

	localparam int ENTRY_BITS = $bits(tbl_entry_t);

endpackage : lps_pkg

`default_nettype wire

// ===== rtl/core/lps_ram.sv =====
// lps_ram: generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lps_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule : lps_ram

`default_nettype wire

// ===== rtl/core/lps_tick_unit.sv =====
// lps_tick_unit: shared remaining-time update, moves a signed time toward
// zero by the tick period and clears it when within one period.
// Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lps_tick_unit #(
	parameter int DURATION_BITS = lps_pkg::DURATION_BITS_DEF
) (
	input  wire logic signed [DURATION_BITS-1:0]     rem_in,
	input  wire logic        [lps_pkg::TICK_BITS-1:0] tick_ms,
	output logic signed      [DURATION_BITS-1:0]     rem_out,
	output logic                                     rem_zero
);
	import lps_pkg::*;

	// wide enough for duration plus or minus a full tick
	localparam int W = ((DURATION_BITS > TICK_BITS) ? DURATION_BITS : TICK_BITS) + 2;

	logic signed [W-1:0] r;
	logic signed [W-1:0] t;
	logic signed [W-1:0] diff;
	logic signed [W-1:0] sum;

	assign r    = W'(rem_in);
	assign t    = $signed(W'(tick_ms));
	assign diff = r - t;
	assign sum  = r + t;

	always_comb begin
		if (diff > 0) begin
			rem_out = DURATION_BITS'(diff);
		end else if (sum < 0) begin
			rem_out = DURATION_BITS'(sum);
		end else begin
			rem_out = '0;
		end
	end

	assign rem_zero = (rem_out == '0);

endmodule : lps_tick_unit

`default_nettype wire

// ===== rtl/core/led_pattern_sequencer.sv =====
// led_pattern_sequencer: top level of the multi-channel LED pattern player.
// Depends on lps_pkg, lps_ram and lps_tick_unit.
// Flow: a table write, out-of-range or no-op command goes to the done state;
// a restart first loads step zero of its pattern; a tick walks every channel,
// loading the next entry where a step is due and step one after a continue.
// Throughput: one item at a time, set by the single tick unit and the one
// table RAM port walking the channels in order.
// Reset: channels stopped and dark, tick period 10 ms; table contents undefined.
`timescale 1ns / 1ps
`default_nettype none

module led_pattern_sequencer #(
	parameter int CHANNELS      = lps_pkg::CHANNELS_DEF,
	parameter int PATTERNS      = lps_pkg::PATTERNS_DEF,
	parameter int STEPS         = lps_pkg::STEPS_DEF,
	parameter int DURATION_BITS = lps_pkg::DURATION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// config write channel (tick period in ms)
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lps_pkg::TICK_BITS-1:0]     cfg_data,
	// command channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lps_pkg::FUNC_BITS-1:0]     func,
	input  wire logic [lps_pkg::IDX_BITS-1:0]      channel,
	input  wire logic [lps_pkg::IDX_BITS-1:0]      pattern,
	input  wire logic [lps_pkg::IDX_BITS-1:0]      step_index,
	input  wire logic [lps_pkg::ACT_BITS-1:0]      step_action,
	input  wire logic signed [lps_pkg::DUR_IN_BITS-1:0] step_duration,
	// status channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lps_pkg::OUT_BITS-1:0]           led_levels,
	output logic [lps_pkg::OUT_BITS-1:0]           active_mask
);
	import lps_pkg::*;

	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int SW    = $clog2(STEPS);
	localparam int DEPTH = PATTERNS * STEPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int DB    = DURATION_BITS;

	localparam logic [CW-1:0] LAST_CH  = CW'(CHANNELS - 1);
	localparam logic [SW-1:0] LAST_STP = SW'(STEPS - 1);
	localparam logic [SW-1:0] STEP_ONE = SW'(1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TICK = 3'd1; // update one channel's time
	localparam logic [2:0] S_LOAD = 3'd2; // table read data is back
	localparam logic [2:0] S_DONE = 3'd3; // hand status to output register

	function automatic logic [AW-1:0] tbl_addr(input logic [PW-1:0] p, input logic [SW-1:0] s);
		return AW'(p) * AW'(STEPS) + AW'(s);
	endfunction

	// control
	logic [2:0]           state_q;
	logic [FUNC_BITS-1:0] func_q;
	logic [CW-1:0]        ch_q;
	logic                 cont_q;   // second read after a continue step
	logic [TICK_BITS-1:0] tick_ms_q;
	logic                 out_valid_q;
	logic [OUT_BITS-1:0]  led_out_q;
	logic [OUT_BITS-1:0]  act_out_q;

	// per-channel state
	logic [PW-1:0]          pat_q  [CHANNELS];
	logic [SW-1:0]          step_q [CHANNELS];
	logic signed [DB-1:0]   rem_q  [CHANNELS];
	logic [ACT_BITS-1:0]    act_q  [CHANNELS];
	logic [CHANNELS-1:0]    led_q;

	// table RAM port
	logic                  ram_en;
	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [ENTRY_BITS-1:0] ram_rdata;
	tbl_entry_t            wr_entry;
	tbl_entry_t            rd_entry;
	logic signed [DB-1:0]  rd_rem;

	logic                  in_fire;
	logic                  restart_ok;
	logic                  write_ok;
	logic [SW-1:0]         nxt_step;
	logic signed [DB-1:0]  tick_rem;
	logic                  tick_zero;
	logic                  step_due;
	logic                  need_cont;
	logic [OUT_BITS-1:0]   lv_now;
	logic [OUT_BITS-1:0]   am_now;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign led_levels  = led_out_q;
	assign active_mask = act_out_q;

	// commands naming a channel, pattern or step beyond the build are dropped
	assign restart_ok = (32'(channel) < CHANNELS) && (32'(pattern) < PATTERNS);
	assign write_ok   = (32'(pattern) < PATTERNS) && (32'(step_index) < STEPS);

	assign wr_entry.action   = step_action;
	assign wr_entry.duration = step_duration;
	assign rd_entry          = tbl_entry_t'(ram_rdata);
	// stored duration truncated or sign-extended to the counter width
	assign rd_rem            = DB'($signed(rd_entry.duration));

	// shared channel update unit, fed by the channel under the pointer
	lps_tick_unit #(
		.DURATION_BITS(DB)
	) u_tick (
		.rem_in  (rem_q[ch_q]),
		.tick_ms (tick_ms_q),
		.rem_out (tick_rem),
		.rem_zero(tick_zero)
	);

	assign nxt_step  = (step_q[ch_q] == LAST_STP) ? '0 : step_q[ch_q] + STEP_ONE;
	assign step_due  = tick_zero && (act_q[ch_q] != ACT_STOP);
	// a continue reached by stepping jumps to step one once; never on restart
	assign need_cont = (func_q == FUNC_TICK) && !cont_q && (rd_entry.action == ACT_CONTINUE);

	// RAM requests
	always_comb begin
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && func == FUNC_WRITE && write_ok) begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = tbl_addr(PW'(pattern), SW'(step_index));
				end else if (in_fire && func == FUNC_RESTART && restart_ok) begin
					ram_en   = 1'b1;
					ram_addr = tbl_addr(PW'(pattern), '0);
				end
			end
			S_TICK: begin
				if (step_due) begin
					ram_en   = 1'b1;
					ram_addr = tbl_addr(pat_q[ch_q], nxt_step);
				end
			end
			S_LOAD: begin
				if (need_cont) begin
					ram_en   = 1'b1;
					ram_addr = tbl_addr(pat_q[ch_q], STEP_ONE);
				end
			end
			default: ;
		endcase
	end

	lps_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_entry),
		.rdata(ram_rdata)
	);

	// visible status: channels 0..7 only
	for (genvar i = 0; i < OUT_BITS; i++) begin : g_status
		if (i < CHANNELS) begin : g_live
			assign lv_now[i] = led_q[i];
			assign am_now[i] = (act_q[i] != ACT_STOP);
		end else begin : g_none
			assign lv_now[i] = 1'b0;
			assign am_now[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FUNC_TICK;
			ch_q        <= '0;
			cont_q      <= 1'b0;
			tick_ms_q   <= TICK_MS_RESET;
			out_valid_q <= 1'b0;
			led_out_q   <= '0;
			act_out_q   <= '0;
			led_q       <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pat_q[i]  <= '0;
				step_q[i] <= '0;
				rem_q[i]  <= '0;
				act_q[i]  <= ACT_STOP;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				tick_ms_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						func_q <= func;
						cont_q <= 1'b0;
						ch_q   <= '0;
						state_q <= S_DONE;
						if (func == FUNC_TICK) begin
							state_q <= S_TICK;
						end else if (func == FUNC_RESTART && restart_ok) begin
							ch_q                 <= CW'(channel);
							pat_q[CW'(channel)]  <= PW'(pattern);
							step_q[CW'(channel)] <= '0;
							state_q              <= S_LOAD;
						end
					end
				end

				S_TICK: begin
					rem_q[ch_q] <= tick_rem;
					cont_q      <= 1'b0;
					if (step_due) begin
						step_q[ch_q] <= nxt_step;
						state_q      <= S_LOAD;
					end else if (ch_q == LAST_CH) begin
						state_q <= S_DONE;
					end else begin
						ch_q <= ch_q + CW'(1);
					end
				end

				S_LOAD: begin
					act_q[ch_q] <= rd_entry.action;
					rem_q[ch_q] <= rd_rem;
					if (need_cont) begin
						// wait for step one's entry
						step_q[ch_q] <= STEP_ONE;
						cont_q       <= 1'b1;
					end else begin
						cont_q <= 1'b0;
						if (func_q == FUNC_TICK) begin
							unique case (rd_entry.action)
								ACT_ON:     led_q[ch_q] <= 1'b1;
								ACT_OFF:    led_q[ch_q] <= 1'b0;
								ACT_TOGGLE: led_q[ch_q] <= ~led_q[ch_q];
								default:    ;
							endcase
							if (ch_q == LAST_CH) begin
								state_q <= S_DONE;
							end else begin
								ch_q    <= ch_q + CW'(1);
								state_q <= S_TICK;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end

				S_DONE: begin
					// result waits here while the previous transfer is pending
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						led_out_q   <= lv_now;
						act_out_q   <= am_now;
						state_q     <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the channel pointer never leaves the built channels
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ch_q) < CHANNELS)
		else $error("channel pointer out of range");

	// an accepted command always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted command left sequencer idle");

	// continue re-read only happens in the load state on a tick
	a_cont_load: assert property (@(posedge clk) disable iff (!arst_n)
		cont_q |-> (state_q == S_LOAD) && (func_q == FUNC_TICK))
		else $error("continue flag outside a tick load");

	// leaving the done state always presents a result
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && (!out_valid_q || out_ready) |=> out_valid_q && state_q == S_IDLE)
		else $error("done state did not present a result");

	// no table access while waiting on the output side
	a_ram_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !ram_en)
		else $error("table access while handing off result");

endmodule : led_pattern_sequencer

`default_nettype wire
